### rtl/fss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fss_pkg
// Shared types and constants of the slave serial configuration sequencer.
// ----------------------------------------------------------------------------
package fss_pkg;

   localparam int INIT_LIMIT_W = 24;
   localparam int DONE_LIMIT_W = 8;
   localparam int CSR_DATA_W   = 24;

   localparam logic [INIT_LIMIT_W-1:0] INIT_LIMIT_RESET = 24'hFFFFFF;
   localparam logic [DONE_LIMIT_W-1:0] DONE_LIMIT_RESET = 8'd255;

   // register indexes on the csr port
   localparam logic CSR_INIT_POLL_LIMIT  = 1'b0;
   localparam logic CSR_DONE_PULSE_LIMIT = 1'b1;

   // step numbers inside a job
   localparam logic [3:0] BYTE_LAST_STEP = 4'd15;
   localparam logic [3:0] PULSE_FIN_STEP = 4'd2;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_DATA  = 2'd1,
      OP_POLL  = 2'd2,
      OP_END   = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_BUSY         = 3'd0,
      ST_READY        = 3'd1,
      ST_CONFIGURED   = 3'd2,
      ST_STUCK_HIGH   = 3'd3,
      ST_STUCK_LOW    = 3'd4,
      ST_DONE_TIMEOUT = 3'd5,
      ST_REJECTED     = 3'd6
   } status_type;

   // SINGLE: one result; BYTE: sixteen shift results; PULSE: one clock pulse,
   // optionally followed by the finishing result
   typedef enum logic [1:0] {
      JOB_SINGLE = 2'd0,
      JOB_BYTE   = 2'd1,
      JOB_PULSE  = 2'd2
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic         prog;
      logic         clk;
      logic         data;
      logic [7:0]   byte_val;
      logic         fin;
      status_type   status;
   } job_type;

endpackage

### rtl/fss_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fss_front
// Accepts items, runs the sequencer state and issues one job per item.
// ----------------------------------------------------------------------------
module fss_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  fss_pkg::opcode_type                  req_opcode,
   input  logic [7:0]                           req_data_byte,
   input  logic                                 req_init_pin,
   input  logic                                 req_done_pin,
   input  logic                                 csr_we,
   input  logic                                 csr_index,
   input  logic [fss_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                 q_full,
   output logic                                 q_push,
   output fss_pkg::job_type                     q_job
);
   import fss_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_WAIT_LOW,
      PH_WAIT_HIGH,
      PH_READY,
      PH_DONE_WAIT,
      PH_CONFIGURED
   } phase_type;

   phase_type                phase_ff, phase_in;
   logic [INIT_LIMIT_W-1:0]  wait_count_ff, wait_count_in;
   logic                     prog_ff, prog_in;
   logic                     clk_ff, clk_in;
   logic                     data_ff, data_in;
   logic [INIT_LIMIT_W-1:0]  init_limit_ff;
   logic [DONE_LIMIT_W-1:0]  done_limit_ff;

   logic                     accept;
   logic                     first_wait;
   logic                     pin_old;
   logic                     iw_lt;
   logic [INIT_LIMIT_W-1:0]  iw_inc;
   logic                     iw_hit;
   logic [INIT_LIMIT_W-1:0]  dw_base;
   logic [INIT_LIMIT_W-1:0]  dw_limit;
   logic [INIT_LIMIT_W-1:0]  dw_inc;
   logic                     dw_lt;
   logic                     dw_lt_inc;
   logic                     dw_pulse;
   logic                     dw_finish;
   logic                     dw_timeout;
   job_type                  job;

   // hold off items while in reset
   assign req_ready = !q_full && !reset;
   assign accept    = req_valid && req_ready;
   assign q_push    = accept;
   assign q_job     = job;

   // init wait: pin_old means the pin still shows the level being left
   assign first_wait = (phase_ff == PH_WAIT_LOW);
   assign pin_old    = first_wait ? req_init_pin : !req_init_pin;
   assign iw_lt      = wait_count_ff < init_limit_ff;
   assign iw_inc     = wait_count_ff + INIT_LIMIT_W'(1);
   assign iw_hit     = !(iw_inc < init_limit_ff);

   // done wait starts from zero when entered from ready
   assign dw_base    = (phase_ff == PH_READY) ? '0 : wait_count_ff;
   assign dw_limit   = INIT_LIMIT_W'(done_limit_ff);
   assign dw_inc     = dw_base + INIT_LIMIT_W'(1);
   assign dw_lt      = dw_base < dw_limit;
   assign dw_lt_inc  = dw_inc < dw_limit;
   assign dw_pulse   = !req_done_pin && dw_lt;
   assign dw_finish  = !dw_pulse || !dw_lt_inc;
   assign dw_timeout = dw_pulse ? !dw_lt_inc : !dw_lt;

   always_comb begin
      phase_in      = phase_ff;
      wait_count_in = wait_count_ff;
      prog_in       = prog_ff;
      clk_in        = clk_ff;
      data_in       = data_ff;
      job.kind      = JOB_SINGLE;
      job.byte_val  = req_data_byte;
      job.fin       = 1'b0;
      job.status    = ST_REJECTED;

      priority if (req_opcode == OP_START) begin
         prog_in       = 1'b0;
         clk_in        = 1'b0;
         wait_count_in = '0;
         phase_in      = PH_WAIT_LOW;
         job.status    = ST_BUSY;
      end else if (req_opcode == OP_DATA) begin
         if (phase_ff == PH_READY) begin
            job.kind   = JOB_BYTE;
            job.status = ST_READY;
            clk_in     = 1'b1;
            data_in    = req_data_byte[0];
         end
      end else if ((phase_ff == PH_WAIT_LOW || phase_ff == PH_WAIT_HIGH)
                   && req_opcode == OP_POLL) begin
         priority if (pin_old && iw_lt && !iw_hit) begin
            wait_count_in = iw_inc;
            job.status    = ST_BUSY;
         end else if (!pin_old && iw_lt) begin
            wait_count_in = '0;
            if (first_wait) begin
               prog_in    = 1'b1;
               phase_in   = PH_WAIT_HIGH;
               job.status = ST_BUSY;
            end else begin
               phase_in   = PH_READY;
               job.status = ST_READY;
            end
         end else begin
            // timeout: count steps up to the limit or stays where it is
            if (pin_old && iw_lt) begin
               wait_count_in = iw_inc;
            end
            phase_in = PH_IDLE;
            if (first_wait) begin
               prog_in    = 1'b1;
               job.status = ST_STUCK_HIGH;
            end else begin
               job.status = ST_STUCK_LOW;
            end
         end
      end else if (phase_ff == PH_DONE_WAIT
                   || (phase_ff == PH_READY && req_opcode == OP_END)) begin
         wait_count_in = dw_pulse ? dw_inc : dw_base;
         job.fin       = dw_finish;
         job.status    = dw_timeout ? ST_DONE_TIMEOUT : ST_CONFIGURED;
         if (dw_pulse) begin
            job.kind = JOB_PULSE;
         end
         if (dw_finish) begin
            clk_in   = 1'b0;
            data_in  = 1'b0;
            phase_in = dw_timeout ? PH_IDLE : PH_CONFIGURED;
         end else begin
            clk_in   = 1'b1;
            phase_in = PH_DONE_WAIT;
         end
      end else if (phase_ff == PH_READY) begin
         job.status = ST_READY;
      end else if (phase_ff == PH_CONFIGURED && req_opcode == OP_POLL) begin
         job.status = ST_CONFIGURED;
      end else begin
         job.status = ST_REJECTED;
      end

      // single results and finished pulses carry the levels after the step;
      // byte and pulse jobs start from the current levels
      if (job.kind == JOB_SINGLE) begin
         job.prog = prog_in;
         job.clk  = clk_in;
         job.data = data_in;
      end else begin
         job.prog = prog_ff;
         job.clk  = clk_ff;
         job.data = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         wait_count_ff <= '0;
         prog_ff       <= 1'b1;
         clk_ff        <= 1'b0;
         data_ff       <= 1'b0;
         init_limit_ff <= INIT_LIMIT_RESET;
         done_limit_ff <= DONE_LIMIT_RESET;
      end else begin
         if (accept) begin
            phase_ff      <= phase_in;
            wait_count_ff <= wait_count_in;
            prog_ff       <= prog_in;
            clk_ff        <= clk_in;
            data_ff       <= data_in;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_INIT_POLL_LIMIT:  init_limit_ff <= csr_wdata[INIT_LIMIT_W-1:0];
               CSR_DONE_PULSE_LIMIT: done_limit_ff <= csr_wdata[DONE_LIMIT_W-1:0];
               default: ;
            endcase
         end
      end
   end

endmodule

### rtl/fss_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fss_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module fss_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fss_pkg::job_type  push_job,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output fss_pkg::job_type  head_job
);
   import fss_pkg::*;

   job_type     entry_ff [2];
   logic        wr_ptr_ff;
   logic        rd_ptr_ff;
   logic [1:0]  count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("job pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("job popped from an empty queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

### rtl/fss_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fss_back
// Expands queued jobs into pin-level result items, one per cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
module fss_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  fss_pkg::job_type  head_job,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_prog,
   output logic              rsp_clk,
   output logic              rsp_data,
   output fss_pkg::status_type rsp_status,
   output logic              rsp_last
);
   import fss_pkg::*;

   logic        rsp_valid_ff;
   logic        prog_ff, clk_ff, data_ff, last_ff;
   status_type  status_ff;
   logic [3:0]  step_ff;

   logic        advance;
   logic        step_last;
   logic        r_prog, r_clk, r_data;
   status_type  r_status;

   assign advance    = !rsp_valid_ff || rsp_ready;
   assign pop        = advance && head_valid && step_last;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_prog   = prog_ff;
   assign rsp_clk    = clk_ff;
   assign rsp_data   = data_ff;
   assign rsp_status = status_ff;
   assign rsp_last   = last_ff;

   always_comb begin
      step_last = 1'b1;
      r_prog    = head_job.prog;
      r_clk     = head_job.clk;
      r_data    = head_job.data;
      r_status  = head_job.status;
      unique case (head_job.kind)
         JOB_SINGLE: ;
         JOB_BYTE: begin
            // MSB first, clock low then high for each bit
            r_clk     = step_ff[0];
            r_data    = head_job.byte_val[3'd7 - step_ff[3:1]];
            r_status  = ST_READY;
            step_last = (step_ff == BYTE_LAST_STEP);
         end
         JOB_PULSE: begin
            if (step_ff == PULSE_FIN_STEP) begin
               r_clk  = 1'b0;
               r_data = 1'b0;
            end else begin
               r_clk     = step_ff[0];
               r_status  = ST_BUSY;
               step_last = step_ff[0] && !head_job.fin;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         step_ff      <= 4'd0;
      end else if (advance) begin
         rsp_valid_ff <= head_valid;
         if (head_valid) begin
            step_ff <= step_last ? 4'd0 : step_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && head_valid) begin
         prog_ff   <= r_prog;
         clk_ff    <= r_clk;
         data_ff   <= r_data;
         status_ff <= r_status;
         last_ff   <= step_last;
      end
   end

   a_single_step: assert property (@(posedge clock) disable iff (reset)
      (head_valid && head_job.kind == JOB_SINGLE) |-> step_ff == 4'd0)
      else $error("single job past its first step");

   a_pulse_step: assert property (@(posedge clock) disable iff (reset)
      (head_valid && head_job.kind == JOB_PULSE) |-> step_ff <= PULSE_FIN_STEP)
      else $error("pulse job step out of range");

   a_idle_step: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> step_ff == 4'd0)
      else $error("step counter busy without a job");

endmodule

### rtl/fpga_slave_serial_config_top.sv
`timescale 1ns / 1ps
// The first result of an item is registered: the job is first written into the queue and then,
// when the back end is free, loaded into the output register.
// A start, poll or rejected item yields one result, a done-wait step one to three,
// a data byte sixteen: the back end emits one result per cycle while rsp_tready is high.
// A two-entry job queue lets the front accept one item per cycle, until the queue is full, while the back still shifts.
// Synchronous reset: program high, clock and data low, idle, limits at maximum, ready low.
// ----------------------------------------------------------------------------
// fpga_slave_serial_config_top
// Slave serial configuration sequencer: front, job queue and shift back end.
// ----------------------------------------------------------------------------
module fpga_slave_serial_config_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [15:0]                        req_tdata,  // data_byte[7:0], init_pin, done_pin
   input  logic [1:0]                         req_tuser,  // opcode
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [7:0]                         rsp_tdata,  // prog, clock, data, status[2:0]
   output logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic                               csr_index,
   input  logic [fss_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import fss_pkg::*;

   logic        q_full;
   logic        q_push;
   job_type     q_job;
   logic        q_pop;
   logic        head_valid;
   job_type     head_job;
   logic        out_prog, out_clk, out_data;
   status_type  out_status;

   fss_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req_opcode    (opcode_type'(req_tuser)),
      .req_data_byte (req_tdata[7:0]),
      .req_init_pin  (req_tdata[8]),
      .req_done_pin  (req_tdata[9]),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_job         (q_job)
   );

   fss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_job),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   fss_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_prog   (out_prog),
      .rsp_clk    (out_clk),
      .rsp_data   (out_data),
      .rsp_status (out_status),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, out_status, out_data, out_clk, out_prog};

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the slave serial configuration sequencer. Items go
// in through the request stream, and every pin-level result is compared,
// field by field, with a cycle-free model of the sequence: program and init
// waits, MSB-first byte shifting, the done wait, timeouts and rejections.
// Directed cases come first, then random configuration runs under three limit
// settings and three idle patterns on both stream sides.
// ----------------------------------------------------------------------------
module testbench;
   import fss_pkg::*;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_WAIT_LOW,
      SEQ_WAIT_HIGH,
      SEQ_READY,
      SEQ_DONE_WAIT,
      SEQ_CONFIGURED
   } seq_phase_type;

   typedef struct packed {
      logic       prog;
      logic       clk;
      logic       data;
      status_type status;
      logic       last;
   } pin_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata  = '0;   // data_byte[7:0], init_pin, done_pin
   logic [1:0]            req_tuser  = '0;   // opcode
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;         // prog, clock, data, status[2:0]
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   logic                  csr_index  = 1'b0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // sequencer copy: limits, phase, counter and pin levels
   logic [INIT_LIMIT_W-1:0] init_limit_m;
   logic [DONE_LIMIT_W-1:0] done_limit_m;
   logic [23:0]             wait_count;
   seq_phase_type           seq_phase;
   logic                    prog_m;
   logic                    clk_m;
   logic                    data_m;

   pin_result_type pending_pins[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int items_sent    = 0;
   int results_seen  = 0;
   int error_count   = 0;

   fpga_slave_serial_config_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // pin sequence prediction
   // ------------------------------------------------------------------------
   function automatic void emit_pins(status_type st);
      pending_pins.push_back('{prog: prog_m, clk: clk_m, data: data_m, status: st, last: 1'b0});
   endfunction

   function automatic void step_init_wait(logic pin_old, logic first);
      if (pin_old || wait_count >= init_limit_m) begin
         if (pin_old && wait_count < init_limit_m)
            wait_count = wait_count + 24'd1;
         if (wait_count >= init_limit_m) begin
            seq_phase = SEQ_IDLE;
            if (first) begin
               prog_m = 1'b1;
               emit_pins(ST_STUCK_HIGH);
            end else begin
               emit_pins(ST_STUCK_LOW);
            end
         end else begin
            emit_pins(ST_BUSY);
         end
      end else begin
         wait_count = '0;
         if (first) begin
            prog_m    = 1'b1;
            seq_phase = SEQ_WAIT_HIGH;
            emit_pins(ST_BUSY);
         end else begin
            seq_phase = SEQ_READY;
            emit_pins(ST_READY);
         end
      end
   endfunction

   function automatic void step_done_wait(logic done_pin);
      logic finish;
      finish = 1'b1;
      if (!done_pin && wait_count < {16'd0, done_limit_m}) begin
         clk_m = 1'b0;
         emit_pins(ST_BUSY);
         clk_m = 1'b1;
         emit_pins(ST_BUSY);
         wait_count = wait_count + 24'd1;
         finish = (wait_count >= {16'd0, done_limit_m});
      end
      if (finish) begin
         clk_m  = 1'b0;
         data_m = 1'b0;
         if (wait_count >= {16'd0, done_limit_m}) begin
            seq_phase = SEQ_IDLE;
            emit_pins(ST_DONE_TIMEOUT);
         end else begin
            seq_phase = SEQ_CONFIGURED;
            emit_pins(ST_CONFIGURED);
         end
      end
   endfunction

   function automatic void predict_pins(opcode_type op, logic [7:0] byte_val,
                                        logic init_pin, logic done_pin);
      pin_result_type tail;
      int             i;
      case (op)
         OP_START: begin
            prog_m     = 1'b0;
            clk_m      = 1'b0;
            wait_count = '0;
            seq_phase  = SEQ_WAIT_LOW;
            emit_pins(ST_BUSY);
         end
         OP_DATA: begin
            if (seq_phase == SEQ_READY) begin
               for (i = 7; i >= 0; i--) begin
                  clk_m  = 1'b0;
                  data_m = byte_val[i];
                  emit_pins(ST_READY);
                  clk_m = 1'b1;
                  emit_pins(ST_READY);
               end
            end else begin
               emit_pins(ST_REJECTED);
            end
         end
         default: begin
            if (seq_phase == SEQ_WAIT_LOW && op == OP_POLL)
               step_init_wait(init_pin, 1'b1);
            else if (seq_phase == SEQ_WAIT_HIGH && op == OP_POLL)
               step_init_wait(!init_pin, 1'b0);
            else if (seq_phase == SEQ_DONE_WAIT)
               step_done_wait(done_pin);
            else if (seq_phase == SEQ_READY && op == OP_END) begin
               wait_count = '0;
               seq_phase  = SEQ_DONE_WAIT;
               step_done_wait(done_pin);
            end else if (seq_phase == SEQ_READY)
               emit_pins(ST_READY);
            else if (seq_phase == SEQ_CONFIGURED && op == OP_POLL)
               emit_pins(ST_CONFIGURED);
            else
               emit_pins(ST_REJECTED);
         end
      endcase
      // mark the final result of this item
      tail      = pending_pins.pop_back();
      tail.last = 1'b1;
      pending_pins.push_back(tail);
   endfunction

   // ------------------------------------------------------------------------
   // result checking and receiver stalls
   // ------------------------------------------------------------------------
   task automatic report_mismatch(string msg);
      $display("[%0t] mismatch on result %0d: %s", $realtime, results_seen, msg);
      error_count++;
   endtask

   task automatic check_result();
      pin_result_type exp_pins;
      if (pending_pins.size() == 0) begin
         report_mismatch($sformatf("unexpected result tdata=%h tlast=%b", rsp_tdata, rsp_tlast));
      end else begin
         exp_pins = pending_pins.pop_front();
         if (rsp_tdata[0] !== exp_pins.prog)
            report_mismatch($sformatf("prog got %b exp %b", rsp_tdata[0], exp_pins.prog));
         if (rsp_tdata[1] !== exp_pins.clk)
            report_mismatch($sformatf("clock got %b exp %b", rsp_tdata[1], exp_pins.clk));
         if (rsp_tdata[2] !== exp_pins.data)
            report_mismatch($sformatf("data got %b exp %b", rsp_tdata[2], exp_pins.data));
         if (rsp_tdata[5:3] !== exp_pins.status)
            report_mismatch($sformatf("status got %0d exp %0d", rsp_tdata[5:3],
                                      exp_pins.status));
         if (rsp_tlast !== exp_pins.last)
            report_mismatch($sformatf("tlast got %b exp %b", rsp_tlast, exp_pins.last));
      end
      results_seen++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_result();
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   // valid stays high across back-to-back items; drop it only for a gap
   task automatic send_item(opcode_type op, logic [7:0] byte_val, logic init_pin,
                            logic done_pin);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < send_idle_pct)
            @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'd0, done_pin, init_pin, byte_val};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_pins(op, byte_val, init_pin, done_pin);
      items_sent++;
   endtask

   task automatic send_noise_item();
      send_item(opcode_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_pins.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // call only while idle
   task automatic set_limits(logic [INIT_LIMIT_W-1:0] init_lim,
                             logic [DONE_LIMIT_W-1:0] done_lim);
      csr_we    <= 1'b1;
      csr_index <= CSR_INIT_POLL_LIMIT;
      csr_wdata <= init_lim;
      @(posedge clock);
      init_limit_m = init_lim;
      csr_index <= CSR_DONE_PULSE_LIMIT;
      csr_wdata <= {16'd0, done_lim};
      @(posedge clock);
      done_limit_m = done_lim;
      csr_we <= 1'b0;
   endtask

   // one well-formed configuration run with random content and a little noise
   task automatic send_config_sequence();
      int polls;
      int count;
      int k;
      int roll;
      send_item(OP_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
      polls = $urandom_range(0, 3);
      count = 0;
      while (seq_phase == SEQ_WAIT_LOW && count < 8) begin
         send_item(OP_POLL, 8'($urandom_range(0, 255)), (count < polls),
                   1'($urandom_range(0, 1)));
         count++;
      end
      polls = $urandom_range(0, 3);
      count = 0;
      while (seq_phase == SEQ_WAIT_HIGH && count < 8) begin
         send_item(OP_POLL, 8'($urandom_range(0, 255)), (count >= polls),
                   1'($urandom_range(0, 1)));
         count++;
      end
      if (seq_phase == SEQ_READY) begin
         for (k = 0; k < $urandom_range(1, 5); k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
               send_noise_item();
            else if (roll < 18)
               send_item(OP_POLL, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
            else
               send_item(OP_DATA, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
         end
         polls = $urandom_range(0, 5);
         count = 0;
         while ((seq_phase == SEQ_READY || seq_phase == SEQ_DONE_WAIT) && count < 8) begin
            // a poll during the done wait acts like an end item
            send_item((seq_phase == SEQ_DONE_WAIT && $urandom_range(0, 9) == 0) ? OP_POLL
                      : OP_END, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      (count >= polls));
            count++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_rejections();
      send_item(OP_POLL, 8'hFF, 1'b1, 1'b1);
      send_item(OP_DATA, 8'hFF, 1'b0, 1'b0);
      send_item(OP_END, 8'h00, 1'b1, 1'b0);
   endtask

   task automatic test_startup_waits();
      send_item(OP_START, 8'h00, 1'b1, 1'b0);
      send_item(OP_POLL, 8'h00, 1'b1, 1'b0);
      send_item(OP_POLL, 8'h00, 1'b0, 1'b1);
      send_item(OP_DATA, 8'h81, 1'b0, 1'b0);
      send_item(OP_POLL, 8'h00, 1'b0, 1'b0);
      send_item(OP_POLL, 8'hFF, 1'b1, 1'b1);
      send_item(OP_POLL, 8'h00, 1'b0, 1'b0);
   endtask

   task automatic test_data_shift();
      send_item(OP_DATA, 8'h00, 1'b0, 1'b0);
      send_item(OP_DATA, 8'hFF, 1'b1, 1'b1);
      send_item(OP_DATA, 8'h5A, 1'b0, 1'b1);
   endtask

   task automatic test_done_wait();
      send_item(OP_END, 8'h00, 1'b0, 1'b0);
      send_item(OP_END, 8'h00, 1'b0, 1'b1);
      send_item(OP_POLL, 8'h00, 1'b1, 1'b1);
      send_item(OP_DATA, 8'hA5, 1'b0, 1'b0);
      send_item(OP_END, 8'h00, 1'b0, 1'b1);
   endtask

   task automatic test_wait_timeouts();
      wait_for_drain();
      set_limits(24'd1, 8'd1);
      send_item(OP_START, 8'h00, 1'b0, 1'b0);
      send_item(OP_POLL, 8'h00, 1'b1, 1'b0);
      send_item(OP_START, 8'h00, 1'b0, 1'b0);
      send_item(OP_POLL, 8'h00, 1'b0, 1'b0);
      send_item(OP_POLL, 8'h00, 1'b0, 1'b0);
      send_item(OP_START, 8'h00, 1'b0, 1'b0);
      send_item(OP_POLL, 8'h00, 1'b0, 1'b0);
      send_item(OP_POLL, 8'h00, 1'b1, 1'b0);
      send_item(OP_END, 8'h00, 1'b0, 1'b0);
   endtask

   task automatic test_random_traffic(int n_items, logic [INIT_LIMIT_W-1:0] init_lim,
                                      logic [DONE_LIMIT_W-1:0] done_lim,
                                      int send_pct, int recv_pct);
      int target;
      int k;
      wait_for_drain();
      set_limits(init_lim, done_lim);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      target = items_sent + n_items;
      while (items_sent < target) begin
         if ($urandom_range(0, 99) < 25) begin
            for (k = 0; k < $urandom_range(1, 2); k++)
               send_noise_item();
         end
         send_config_sequence();
      end
   endtask

   initial begin
      init_limit_m = INIT_LIMIT_RESET;
      done_limit_m = DONE_LIMIT_RESET;
      wait_count   = '0;
      seq_phase    = SEQ_IDLE;
      prog_m       = 1'b1;
      clk_m        = 1'b0;
      data_m       = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 29;
      recv_idle_pct = 49;
      test_rejections();
      test_startup_waits();
      test_data_shift();
      test_done_wait();
      test_wait_timeouts();
      test_random_traffic(120, 24'd3, 8'd4, 29, 49);
      test_random_traffic(120, 24'hFFFFFF, 8'd255, 49, 29);
      test_random_traffic(120, 24'd1, 8'd2, 0, 0);
      wait_for_drain();

      $display("Sent %0d items and checked %0d pin results.", items_sent, results_seen);
      $display("Covered waits, shifting, done wait, timeouts and rejections at 4 limit sets.");
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Run timed out with %0d results still pending.", pending_pins.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

### files.f
rtl/fss_pkg.sv
rtl/fss_front.sv
rtl/fss_queue.sv
rtl/fss_back.sv
rtl/fpga_slave_serial_config_top.sv
bench/testbench.sv
